// ----- hw/rtl/lags_pkg.sv -----
// Shared types and constants for the life automaton grid stepper.
package lags_pkg;

	localparam logic [6:0] SIZE_MIN   = 7'd3;
	localparam logic [6:0] SIZE_RESET = 7'd64;
	localparam logic [3:0] LIVE_KEEP  = 4'd2;
	localparam logic [3:0] LIVE_BIRTH = 4'd3;

	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_TOGGLE = 3'd1,
		CMD_CLEAR  = 3'd2,
		CMD_STEP   = 3'd3,
		CMD_READ   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CELL,
		ST_CLEAR,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] command;
		logic [5:0] cell_column;
		logic [5:0] cell_row;
		logic       write_value;
	} in_t;

	typedef struct packed {
		logic cell_alive;
		logic coord_error;
	} out_t;

endpackage

// ----- hw/rtl/lags_row_step.sv -----
// Next-generation logic for one grid row from the rows above, at and below it.
module lags_row_step import lags_pkg::*; #(
	parameter int MAX_WIDTH = 64
) (
	input  logic [MAX_WIDTH-1:0] up,
	input  logic [MAX_WIDTH-1:0] mid,
	input  logic [MAX_WIDTH-1:0] down,
	input  logic [6:0]           w_use,
	input  logic                 border_row,
	output logic [MAX_WIDTH-1:0] row_next
);

	logic [MAX_WIDTH+1:0] up_p;
	logic [MAX_WIDTH+1:0] mid_p;
	logic [MAX_WIDTH+1:0] down_p;

	assign up_p   = {1'b0, up, 1'b0};
	assign mid_p  = {1'b0, mid, 1'b0};
	assign down_p = {1'b0, down, 1'b0};

	always_comb begin
		logic [3:0] cnt;
		logic       in_use;
		logic       col_edge;
		row_next = mid;
		for (int c = 0; c < MAX_WIDTH; c++) begin
			cnt = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
				+ 4'(mid_p[c]) + 4'(mid_p[c+2])
				+ 4'(down_p[c]) + 4'(down_p[c+1]) + 4'(down_p[c+2]);
			in_use   = 32'(c) < 32'(w_use);
			col_edge = (c == 0) || (32'(c + 1) == 32'(w_use));
			if (!in_use) begin
				row_next[c] = mid[c];
			end else if (border_row || col_edge) begin
				row_next[c] = 1'b0;
			end else begin
				case (cnt)
					LIVE_KEEP:  row_next[c] = mid[c];
					LIVE_BIRTH: row_next[c] = 1'b1;
					default:    row_next[c] = 1'b0;
				endcase
			end
		end
	end

endmodule

// ----- hw/rtl/life_automaton_grid_stepper.sv -----
// Top level: B3/S23 life grid held in a row-wide memory, with command and result channels.
//
//   channel   dir   handshake            payload
//   cmd       in    cmd_valid/cmd_stall  cmd_data (in_t)
//   rsp       out   rsp_valid/rsp_stall  rsp_data (out_t)
//   apb       in    psel/penable/pready  paddr, pwdata, prdata
//
// In-grid write, toggle and read pass through ST_CELL and ST_DONE before the result beat;
// out-of-grid accesses and unused codes go straight to ST_DONE; clear writes all MAX_HEIGHT
// rows, and step sweeps the h rows in use (h = rows in use), one row per cycle through the
// single memory read port and row update logic.
// After reset a clearing pass over all MAX_HEIGHT rows runs with cmd_stall high.
// A finished result waits in the output register while the next beat is taken.
module life_automaton_grid_stepper import lags_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  in_t         cmd_data,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output out_t        rsp_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int RA_W = $clog2(MAX_HEIGHT);
	localparam int WCAP = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int HCAP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;

	logic [6:0] gw_q, gh_q;
	logic [6:0] w_use, h_use;

	state_t state_q, state_d;
	logic [RA_W-1:0] sweep_q, sweep_d;
	logic [7:0]      step_q, step_d;
	in_t             cmd_q;
	out_t            res_q, res_d;
	logic            rsp_valid_q;
	out_t            rsp_data_q;
	logic [MAX_WIDTH-1:0] up_q, mid_q;

	logic                 mem_we, mem_re;
	logic [RA_W-1:0]      mem_waddr, mem_raddr;
	logic [MAX_WIDTH-1:0] mem_wdata, mem_rdata_q;
	logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];

	logic                 cmd_take, win_shift, rsp_load;
	logic [MAX_WIDTH-1:0] col_mask, row_next;
	logic                 border_row;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= SIZE_RESET;
			gh_q <= SIZE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_GRID_WIDTH:  gw_q <= pwdata[6:0];
				REG_GRID_HEIGHT: gh_q <= pwdata[6:0];
				default:         gw_q <= gw_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GRID_WIDTH:  prdata = {25'd0, gw_q};
			REG_GRID_HEIGHT: prdata = {25'd0, gh_q};
			default:         prdata = '0;
		endcase
	end

	assign w_use = (gw_q < SIZE_MIN) ? SIZE_MIN : ((gw_q > 7'(WCAP)) ? 7'(WCAP) : gw_q);
	assign h_use = (gh_q < SIZE_MIN) ? SIZE_MIN : ((gh_q > 7'(HCAP)) ? 7'(HCAP) : gh_q);

	// grid memory, one row per entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= grid_mem[mem_raddr];
		end
	end

	assign col_mask   = {{(MAX_WIDTH-1){1'b0}}, 1'b1} << cmd_q.cell_column;
	assign border_row = (step_q == 8'd2) || (step_q == ({1'b0, h_use} + 8'd1));

	lags_row_step #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_row_step (
		.up        (up_q),
		.mid       (mid_q),
		.down      (mem_rdata_q),
		.w_use     (w_use),
		.border_row(border_row),
		.row_next  (row_next)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			step_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			step_q  <= step_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cmd_take) begin
			cmd_q <= cmd_data;
		end
		if (win_shift) begin
			up_q  <= mid_q;
			mid_q <= mem_rdata_q;
		end
		if (rsp_load) begin
			rsp_data_q <= res_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		sweep_d   = sweep_q;
		step_d    = step_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = sweep_q;
		mem_raddr = RA_W'(cmd_data.cell_row);
		mem_wdata = '0;
		cmd_take  = 1'b0;
		win_shift = 1'b0;
		rsp_load  = 1'b0;
		case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
				if (sweep_q == RA_W'(MAX_HEIGHT - 1)) begin
					sweep_d = '0;
					state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
				end else begin
					sweep_d = sweep_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_take = 1'b1;
					res_d    = '0;
					case (cmd_data.command)
						CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
							if (({1'b0, cmd_data.cell_column} >= w_use) ||
								({1'b0, cmd_data.cell_row} >= h_use)) begin
								res_d.coord_error = 1'b1;
								state_d = ST_DONE;
							end else begin
								mem_re  = 1'b1;
								state_d = ST_CELL;
							end
						end
						CMD_CLEAR: begin
							sweep_d = '0;
							state_d = ST_CLEAR;
						end
						CMD_STEP: begin
							step_d  = '0;
							state_d = ST_STEP;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_CELL: begin
				mem_waddr = RA_W'(cmd_q.cell_row);
				case (cmd_q.command)
					CMD_READ: res_d.cell_alive = |(mem_rdata_q & col_mask);
					CMD_WRITE: begin
						mem_we    = 1'b1;
						mem_wdata = cmd_q.write_value ? (mem_rdata_q | col_mask)
							: (mem_rdata_q & ~col_mask);
					end
					CMD_TOGGLE: begin
						mem_we    = 1'b1;
						mem_wdata = mem_rdata_q ^ col_mask;
					end
					default: res_d = res_q;
				endcase
				state_d = ST_DONE;
			end
			ST_STEP: begin
				// read row j, update row j-2 from the window and the row just read
				mem_raddr = RA_W'(step_q);
				mem_waddr = RA_W'(step_q - 8'd2);
				mem_wdata = row_next;
				if (step_q < {1'b0, h_use}) begin
					mem_re = 1'b1;
				end
				if (step_q != 8'd0) begin
					win_shift = 1'b1;
				end
				if (step_q >= 8'd2) begin
					mem_we = 1'b1;
				end
				if (step_q == ({1'b0, h_use} + 8'd1)) begin
					state_d = ST_DONE;
				end else begin
					step_d = step_q + 8'd1;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("grid memory written while idle");

	a_rw_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("row read and written in the same cycle");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (step_q <= ({1'b0, h_use} + 8'd1)))
		else $error("step row counter past the grid");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_DONE))
		else $error("result beat not issued from completion");

endmodule

// ----- sim/life_automaton_grid_stepper_test.sv -----
// Self-checking testbench: directed plan then paced random command beats, scored by a grid model.
module life_automaton_grid_stepper_test;
	import lags_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_MAX = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 6;
	localparam int BEATS_PER_PHASE = 18;
	localparam logic [2:0] CMD_SPARE_LO = 3'd5;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {ROW_BEAT, ROW_WIDTH, ROW_HEIGHT} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_t;

	typedef struct {
		row_kind_t  kind;
		logic [6:0] size;
		in_t        beat;
		bit         pinned;
		out_t       pinned_rsp;
	} plan_row_t;

	typedef struct {
		in_t  beat;
		out_t rsp;
	} cell_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	in_t         cmd_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	out_t        rsp_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	life_automaton_grid_stepper dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_data(cmd_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	logic [6:0]   cfg_width = SIZE_RESET;
	logic [6:0]   cfg_height = SIZE_RESET;
	logic         life_now [GRID_MAX][GRID_MAX];
	logic         life_snap [GRID_MAX][GRID_MAX];
	cell_result_t cell_result_q [$];
	plan_row_t    plan [$];
	int           mismatch_count = 0;
	int           burst_left = 0;
	int           cycle_count = 0;

	task automatic report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	function automatic int span(logic [6:0] v);
		if (v < SIZE_MIN) return SIZE_MIN;
		if (v > GRID_MAX) return GRID_MAX;
		return v;
	endfunction

	// grid model: applies one command, returns the result beat it causes
	function automatic out_t life_apply(in_t beat);
		int   w, h, live;
		out_t rsp;
		w = span(cfg_width);
		h = span(cfg_height);
		rsp = '0;
		case (beat.command)
			CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
				if (beat.cell_column >= w || beat.cell_row >= h) begin
					rsp.coord_error = 1'b1;
				end else if (beat.command == CMD_WRITE) begin
					life_now[beat.cell_row][beat.cell_column] = beat.write_value;
				end else if (beat.command == CMD_TOGGLE) begin
					life_now[beat.cell_row][beat.cell_column] =
						~life_now[beat.cell_row][beat.cell_column];
				end else begin
					rsp.cell_alive = life_now[beat.cell_row][beat.cell_column];
				end
			end
			CMD_CLEAR: begin
				for (int r = 0; r < GRID_MAX; r++)
					for (int c = 0; c < GRID_MAX; c++)
						life_now[r][c] = 1'b0;
			end
			CMD_STEP: begin
				life_snap = life_now;
				for (int r = 0; r < h; r++) begin
					for (int c = 0; c < w; c++) begin
						if (r == 0 || c == 0 || r == h - 1 || c == w - 1) begin
							life_now[r][c] = 1'b0;
						end else begin
							live = 0;
							for (int dr = -1; dr <= 1; dr++)
								for (int dc = -1; dc <= 1; dc++)
									if (dr != 0 || dc != 0)
										live += life_snap[r + dr][c + dc];
							if (live < LIVE_KEEP || live > LIVE_BIRTH)
								life_now[r][c] = 1'b0;
							else if (live == LIVE_BIRTH)
								life_now[r][c] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic plan_row_t beat_row(logic [2:0] op, int col_i, int row_i, bit wv,
			bit pin = 1'b0, bit alive = 1'b0, bit err = 1'b0);
		plan_row_t pr;
		pr.kind = ROW_BEAT;
		pr.size = '0;
		pr.beat.command = op;
		pr.beat.cell_column = 6'(col_i);
		pr.beat.cell_row = 6'(row_i);
		pr.beat.write_value = wv;
		pr.pinned = pin;
		pr.pinned_rsp.cell_alive = alive;
		pr.pinned_rsp.coord_error = err;
		return pr;
	endfunction

	function automatic plan_row_t cfg_row(row_kind_t kind, logic [6:0] size);
		plan_row_t pr;
		pr.kind = kind;
		pr.size = size;
		pr.beat = '0;
		pr.pinned = 1'b0;
		pr.pinned_rsp = '0;
		return pr;
	endfunction

	// bursts of back-to-back beats, mostly separated by idle gaps
	task automatic pace();
		int gap;
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_beat(in_t beat, bit pinned, out_t pinned_rsp);
		cell_result_t pend;
		cmd_valid <= 1'b1;
		cmd_data <= beat;
		do @(posedge clk); while (cmd_stall);
		pend.beat = beat;
		pend.rsp = life_apply(beat);
		if (pinned) pend.rsp = pinned_rsp;
		cell_result_q.push_back(pend);
		pace();
	endtask

	task automatic set_register(logic reg_idx, logic [6:0] value);
		cmd_valid <= 1'b0;
		while (cell_result_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_GRID_WIDTH) cfg_width = value;
		else cfg_height = value;
	endtask

	task automatic random_beat();
		int   roll, w, h;
		in_t  beat;
		w = span(cfg_width);
		h = span(cfg_height);
		roll = $urandom_range(0, 99);
		beat.write_value = ($urandom_range(0, 9) < 7);
		beat.cell_column = 6'($urandom_range(0, (w > 12) ? 12 : w - 1));
		beat.cell_row = 6'($urandom_range(0, (h > 12) ? 12 : h - 1));
		if (roll < 35) begin
			beat.command = CMD_WRITE;
		end else if (roll < 45) begin
			beat.command = CMD_TOGGLE;
		end else if (roll < 70) begin
			beat.command = CMD_READ;
		end else begin
			beat.cell_column = 6'($urandom);
			beat.cell_row = 6'($urandom);
			beat.write_value = 1'($urandom);
			if (roll < 86) beat.command = CMD_STEP;
			else if (roll < 89) beat.command = CMD_CLEAR;
			else if (roll < 94) beat.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			else begin
				case ($urandom_range(0, 2))
					0: beat.command = CMD_WRITE;
					1: beat.command = CMD_TOGGLE;
					default: beat.command = CMD_READ;
				endcase
			end
		end
		send_beat(beat, 1'b0, '0);
	endtask

	// result scoring
	always @(posedge clk) begin
		cell_result_t pend;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cell_result_q.size() == 0) begin
				report_mismatch("result beat with nothing pending");
			end else begin
				pend = cell_result_q.pop_front();
				if (rsp_data.cell_alive !== pend.rsp.cell_alive)
					report_mismatch($sformatf("cell_alive %b exp %b (cmd %0d col %0d row %0d)",
						rsp_data.cell_alive, pend.rsp.cell_alive, pend.beat.command,
						pend.beat.cell_column, pend.beat.cell_row));
				if (rsp_data.coord_error !== pend.rsp.coord_error)
					report_mismatch($sformatf("coord_error %b exp %b (cmd %0d col %0d row %0d)",
						rsp_data.coord_error, pend.rsp.coord_error, pend.beat.command,
						pend.beat.cell_column, pend.beat.cell_row));
			end
		end
	end

	// result-side backpressure
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_window = 0;
	always @(posedge clk) begin
		if (stall_window == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_window <= $urandom_range(16, 160);
		end else begin
			stall_window <= stall_window - 1;
		end
		case (stall_mode)
			STALL_NONE:   rsp_stall <= 1'b0;
			STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
			default:      rsp_stall <= (stall_window[3:0] < 4'd11);
		endcase
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		for (int r = 0; r < GRID_MAX; r++)
			for (int c = 0; c < GRID_MAX; c++) begin
				life_now[r][c] = 1'b0;
				life_snap[r][c] = 1'b0;
			end

		// directed plan
		plan.push_back(beat_row(CMD_READ, 0, 0, 0, 1, 0, 0));
		plan.push_back(beat_row(CMD_READ, 63, 63, 1, 1, 0, 0));
		plan.push_back(beat_row(CMD_WRITE, 63, 63, 1, 1, 0, 0));
		plan.push_back(beat_row(CMD_READ, 63, 63, 0, 1, 1, 0));
		plan.push_back(beat_row(CMD_TOGGLE, 63, 63, 0, 1, 0, 0));
		plan.push_back(beat_row(CMD_READ, 63, 63, 0, 1, 0, 0));
		plan.push_back(beat_row(CMD_TOGGLE, 62, 62, 1));
		// blinker plus a border cell, beside the lonely cell toggled above
		plan.push_back(beat_row(CMD_WRITE, 10, 10, 1));
		plan.push_back(beat_row(CMD_WRITE, 11, 10, 1));
		plan.push_back(beat_row(CMD_WRITE, 12, 10, 1));
		plan.push_back(beat_row(CMD_WRITE, 0, 0, 1));
		plan.push_back(beat_row(CMD_STEP, 63, 63, 1, 1, 0, 0));
		plan.push_back(beat_row(CMD_READ, 11, 9, 0));
		plan.push_back(beat_row(CMD_READ, 10, 10, 0));
		plan.push_back(beat_row(CMD_READ, 62, 62, 0));
		plan.push_back(beat_row(CMD_READ, 0, 0, 0));
		plan.push_back(beat_row(CMD_SPARE_LO, 63, 63, 1, 1, 0, 0));
		plan.push_back(beat_row(CMD_SPARE_HI, 0, 0, 0, 1, 0, 0));
		// out-of-grid addressing, then clamped sizes
		plan.push_back(cfg_row(ROW_WIDTH, 7'd5));
		plan.push_back(cfg_row(ROW_HEIGHT, 7'd4));
		plan.push_back(beat_row(CMD_WRITE, 5, 0, 1, 1, 0, 1));
		plan.push_back(beat_row(CMD_READ, 0, 4, 0, 1, 0, 1));
		plan.push_back(beat_row(CMD_TOGGLE, 11, 9, 0, 1, 0, 1));
		plan.push_back(beat_row(CMD_STEP, 63, 63, 0, 1, 0, 0));
		plan.push_back(cfg_row(ROW_WIDTH, 7'd0));
		plan.push_back(beat_row(CMD_READ, 3, 0, 0, 1, 0, 1));
		plan.push_back(cfg_row(ROW_WIDTH, 7'd127));
		plan.push_back(cfg_row(ROW_HEIGHT, 7'd127));
		plan.push_back(beat_row(CMD_READ, 11, 9, 0));
		plan.push_back(beat_row(CMD_READ, 63, 63, 0));
		plan.push_back(beat_row(CMD_CLEAR, 7, 7, 1, 1, 0, 0));
		plan.push_back(beat_row(CMD_READ, 11, 10, 0, 1, 0, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_WIDTH:  set_register(REG_GRID_WIDTH, plan[i].size);
				ROW_HEIGHT: set_register(REG_GRID_HEIGHT, plan[i].size);
				default:    send_beat(plan[i].beat, plan[i].pinned, plan[i].pinned_rsp);
			endcase
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin
					set_register(REG_GRID_WIDTH, 7'd3);
					set_register(REG_GRID_HEIGHT, 7'd3);
				end
				1: begin
					set_register(REG_GRID_WIDTH, 7'($urandom_range(3, 20)));
					set_register(REG_GRID_HEIGHT, 7'($urandom_range(3, 20)));
				end
				2: begin
					set_register(REG_GRID_WIDTH, 7'd0);
					set_register(REG_GRID_HEIGHT, 7'd70);
				end
				3: begin
					set_register(REG_GRID_WIDTH, 7'd64);
					set_register(REG_GRID_HEIGHT, 7'd5);
				end
				4: begin
					set_register(REG_GRID_WIDTH, 7'd127);
					set_register(REG_GRID_HEIGHT, 7'd64);
				end
				default: begin
					set_register(REG_GRID_WIDTH, 7'($urandom_range(0, 127)));
					set_register(REG_GRID_HEIGHT, 7'($urandom_range(0, 127)));
				end
			endcase
			if ($urandom_range(0, 1) == 0)
				send_beat(in_t'({CMD_CLEAR, 6'($urandom), 6'($urandom), 1'($urandom)}),
					1'b0, '0);
			repeat (BEATS_PER_PHASE) random_beat();
		end

		cmd_valid <= 1'b0;
		while (cell_result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
